/* design/bed_pkg.sv */
// Package for the button/encoder event dispatcher: beat types, codes,
// default sizes and sequencer states. No dependencies.
`default_nettype none

package bed_pkg;

    // Default table geometry
    localparam int SLOTS_PER_KIND_DEF = 2;
    localparam int NUM_KINDS_DEF      = 4;

    // Event kinds
    localparam logic [1:0] KIND_MODE    = 2'd0;
    localparam logic [1:0] KIND_CAPTURE = 2'd1;
    localparam logic [1:0] KIND_OTHER   = 2'd2;
    localparam logic [1:0] KIND_DIAL    = 2'd3;

    // Request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_REG   = 2'd1;
    localparam logic [1:0] REQ_UNREG = 2'd2;

    // Completion status
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ERR       = 2'd1;
    localparam logic [1:0] STAT_BAD_PARAM = 2'd2;

    // Result kinds
    localparam logic RES_COMPLETION = 1'b0;
    localparam logic RES_EVENT      = 1'b1;

    // Configuration register map
    localparam int         PADDR_W     = 3;
    localparam logic [0:0] REG_TPD     = 1'b0;
    localparam logic [3:0] TPD_RESET   = 4'd2;

    // Divider geometry: 16-bit magnitude dividend, divisor up to 15 * 32768
    localparam int DIV_N = 16;
    localparam int DVS_W = 20;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               btn_mode_level;
        logic               btn_capture_level;
        logic               btn_other_level;
        logic [15:0]        encoder_count;
        logic [2:0]         source_kind;
        logic [7:0]         requester_id;
        logic signed [15:0] request_param;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         destination_id;
        logic [1:0]         event_kind;
        logic signed [15:0] event_value;
        logic [1:0]         status_code;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_N-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV_WAIT,
        S_REQ_RD,
        S_REQ_CHK,
        S_FLUSH
    } state_t;

endpackage

`default_nettype wire

/* design/button_encoder_event_dispatcher_unit.sv */
// Top level of the button/encoder event dispatcher: APB register and the
// sequencer. Depends on bed_pkg and bed_ctrl (with bed_ram, bed_div below).
`default_nettype none

// One item is in work at a time; s_ready is high only while the sequencer
// is idle. A tick runs through operand setup, a shift-subtract divider that
// produces one quotient bit per cycle, pickup of the quotient, hand-over of
// the final result and the idle state that takes the next beat. The
// subscriber table is walked one slot at a time through its single read
// port, with a read state and a check state per slot; the walk for pressed
// buttons runs while the divider works and adds time only where it outlasts
// it, and a nonzero dial step adds a walk over the dial slots. Register
// requests walk the slots of their kind up to the first empty one and
// unregister requests walk them all; a request rejected at once goes
// straight to the hand-over. Results leave through an output register, so
// the next item is taken while the final result waits; inside an item a
// result beat is handed over only as the previous one leaves, so a stalled
// receiver stretches the walk and the hand-over. No clearing pass: the table
// has per-entry valid bits that reset clears at once. ticks_per_detent sits
// at byte address 0 and must be written only while the block is idle.
module button_encoder_event_dispatcher_unit #(
    parameter int SLOTS_PER_KIND = bed_pkg::SLOTS_PER_KIND_DEF,
    parameter int NUM_KINDS      = bed_pkg::NUM_KINDS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bed_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire bed_pkg::in_item_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output bed_pkg::out_item_t               m_data
);

    import bed_pkg::*;

    logic [3:0] tpd_reg, tpd_next;
    logic       wr_en;

    // Register write on the access phase
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_TPD);

    always_comb begin
        tpd_next = tpd_reg;
        if (wr_en) begin
            tpd_next = pwdata[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpd_reg <= TPD_RESET;
        end else begin
            tpd_reg <= tpd_next;
        end
    end

    // Read back
    assign prdata = (paddr[2] == REG_TPD) ? {28'h0, tpd_reg} : 32'h0;
    assign pready = 1'b1;

    bed_ctrl #(
        .SLOTS_PER_KIND (SLOTS_PER_KIND),
        .NUM_KINDS      (NUM_KINDS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tpd     (tpd_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* design/bed_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/bed_div.sv */
// Iterative restoring divider on magnitudes, one quotient bit per cycle.
// Depends on bed_pkg.
`default_nettype none

module bed_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bed_pkg::div_req_t req,
    output bed_pkg::div_rsp_t      rsp
);

    import bed_pkg::*;

    localparam int CW = $clog2(DIV_N + 1);

    logic             busy_reg, busy_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_N-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;

    // Shift one dividend bit into the partial remainder, subtract if it fits
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIV_N-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_N);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_N-2:0], 1'b1};
            end else begin
                rem_next = DVS_W'(trial);
                quo_next = {quo_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* design/bed_ctrl.sv */
// Sequencer: button history, encoder reference, subscriber table walk,
// pending/output result registers. Depends on bed_pkg, bed_ram, bed_div.
`default_nettype none

module bed_ctrl #(
    parameter int SLOTS_PER_KIND = bed_pkg::SLOTS_PER_KIND_DEF,
    parameter int NUM_KINDS      = bed_pkg::NUM_KINDS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [3:0]         tpd,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bed_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bed_pkg::out_item_t      m_data
);

    import bed_pkg::*;

    localparam int DEPTH = NUM_KINDS * SLOTS_PER_KIND;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (SLOTS_PER_KIND > 1) ? $clog2(SLOTS_PER_KIND) : 1;

    state_t             state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [2:0]         h0_reg, h0_next;
    logic [2:0]         h1_reg, h1_next;
    logic [2:0]         press_reg, press_next;
    logic [15:0]        ref_reg, ref_next;
    logic signed [15:0] sens_reg, sens_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [2:0]         kind_reg, kind_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic signed [15:0] evv_reg, evv_next;
    logic               hit_reg, hit_next;
    logic               neg_reg, neg_next;
    logic [DIV_N-1:0]   dvd_reg, dvd_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic               pend_valid_reg, pend_valid_next;
    out_item_t          pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;
    logic               rd_valid_reg;

    logic [AW-1:0]      cur_addr;
    logic               ram_we, ram_re;
    logic [7:0]         ram_wdata, ram_rdata, entry;
    logic               last_slot, out_free;
    logic [2:0]         lvl;
    logic [15:0]        diff, sens_mag;
    logic [3:0]         tpd_eff;
    logic signed [15:0] q_val;
    out_item_t          res_evt, res_cpl;
    logic [1:0]         cpl_status;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    bed_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    bed_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Table address and helpers
    assign cur_addr  = AW'(int'(kind_reg) * SLOTS_PER_KIND + int'(slot_reg));
    assign last_slot = (slot_reg == SW'(SLOTS_PER_KIND - 1));
    assign entry     = rd_valid_reg ? ram_rdata : 8'h00;
    assign out_free  = !m_valid_reg || m_ready;
    assign lvl       = {s_data.btn_other_level, s_data.btn_capture_level,
                        s_data.btn_mode_level};
    assign diff      = item_reg.encoder_count - ref_reg;
    assign sens_mag  = sens_reg[15] ? 16'(-sens_reg) : 16'(sens_reg);
    assign tpd_eff   = (tpd == 4'd0) ? 4'd1 : tpd;

    // Signed quotient with saturation of +32768
    always_comb begin
        if (neg_reg) begin
            q_val = -$signed(div_rsp.quotient);
        end else if (div_rsp.quotient[DIV_N-1]) begin
            q_val = 16'sh7FFF;
        end else begin
            q_val = $signed(div_rsp.quotient);
        end
    end

    // Completion status of the slot under check
    always_comb begin
        if (item_reg.req_type == REQ_REG) begin
            cpl_status = (entry == 8'h00) ? STAT_OK : STAT_ERR;
        end else begin
            cpl_status = (hit_reg || entry == item_reg.requester_id) ? STAT_OK : STAT_ERR;
        end
    end

    // Candidate result beats
    always_comb begin
        res_evt = '{result_kind: RES_EVENT, destination_id: entry,
                    event_kind: kind_reg[1:0], event_value: evv_reg,
                    status_code: STAT_OK, last: 1'b0};
        res_cpl = '{result_kind: RES_COMPLETION,
                    destination_id: item_reg.requester_id,
                    event_kind: 2'd0, event_value: 16'sd0,
                    status_code: cpl_status, last: 1'b0};
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        h0_next         = h0_reg;
        h1_next         = h1_reg;
        press_next      = press_reg;
        ref_next        = ref_reg;
        sens_next       = sens_reg;
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        evv_next        = evv_reg;
        hit_next        = hit_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        dvs_next        = dvs_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = 8'h00;
        div_req.start    = 1'b0;
        div_req.dividend = dvd_reg;
        div_req.divisor  = dvs_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    kind_next = 3'(KIND_MODE);
                    slot_next = '0;
                    hit_next  = 1'b0;
                    evv_next  = 16'sd0;
                    if (s_data.req_type == REQ_TICK) begin
                        // Two agreeing samples that differ from the older one
                        press_next = ~lvl & (lvl ^ h1_reg) & ~(lvl ^ h0_reg);
                        for (int b = 0; b < 3; b++) begin
                            if ((lvl[b] != h1_reg[b]) || (lvl[b] != h0_reg[b])) begin
                                h1_next[b] = h0_reg[b];
                            end
                        end
                        h0_next    = lvl;
                        state_next = S_MUL;
                    end else if (s_data.req_type == REQ_REG ||
                                 s_data.req_type == REQ_UNREG) begin
                        if (int'(s_data.source_kind) >= NUM_KINDS) begin
                            pend_valid_next = 1'b1;
                            pend_next = '{result_kind: RES_COMPLETION,
                                          destination_id: s_data.requester_id,
                                          event_kind: 2'd0, event_value: 16'sd0,
                                          status_code: STAT_BAD_PARAM, last: 1'b0};
                            state_next = S_FLUSH;
                        end else begin
                            kind_next  = s_data.source_kind;
                            state_next = S_REQ_RD;
                        end
                    end else begin
                        pend_valid_next = 1'b1;
                        pend_next = '{result_kind: RES_COMPLETION,
                                      destination_id: s_data.requester_id,
                                      event_kind: 2'd0, event_value: 16'sd0,
                                      status_code: STAT_ERR, last: 1'b0};
                        state_next = S_FLUSH;
                    end
                end
            end

            // Divisor product and operand magnitudes
            S_MUL: begin
                dvs_next   = DVS_W'(tpd_eff * sens_mag);
                dvd_next   = diff[15] ? 16'(-diff) : diff;
                neg_next   = diff[15] ^ sens_reg[15];
                state_next = S_DIV_GO;
            end

            S_DIV_GO: begin
                div_req.start = 1'b1;
                state_next    = S_SCAN_RD;
            end

            // Skip buttons without a press, else read the slot
            S_SCAN_RD: begin
                if (kind_reg < 3'(KIND_DIAL) && !press_reg[kind_reg[1:0]]) begin
                    kind_next = kind_reg + 3'd1;
                    if (kind_reg == 3'(KIND_OTHER)) begin
                        state_next = S_DIV_WAIT;
                    end
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (entry == 8'h00 || !pend_valid_reg || out_free) begin
                    if (entry != 8'h00) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = res_evt;
                    end
                    if (last_slot) begin
                        slot_next = '0;
                        if (kind_reg == 3'(KIND_DIAL)) begin
                            state_next = S_FLUSH;
                        end else begin
                            kind_next  = kind_reg + 3'd1;
                            state_next = (kind_reg == 3'(KIND_OTHER)) ? S_DIV_WAIT
                                                                      : S_SCAN_RD;
                        end
                    end else begin
                        slot_next  = slot_reg + SW'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end

            // Dial step once the quotient is ready
            S_DIV_WAIT: begin
                if (!div_rsp.busy) begin
                    if (div_rsp.quotient != '0) begin
                        ref_next   = item_reg.encoder_count;
                        evv_next   = q_val;
                        kind_next  = 3'(KIND_DIAL);
                        slot_next  = '0;
                        state_next = S_SCAN_RD;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_REQ_RD: begin
                ram_re     = 1'b1;
                state_next = S_REQ_CHK;
            end

            // Register fills the first empty slot; unregister clears matches
            S_REQ_CHK: begin
                if (item_reg.req_type == REQ_REG) begin
                    if (entry == 8'h00) begin
                        ram_we             = 1'b1;
                        ram_wdata          = item_reg.requester_id;
                        valid_next[cur_addr] = 1'b1;
                        if (kind_reg == 3'(KIND_DIAL)) begin
                            sens_next = (item_reg.request_param == 16'sd0) ? 16'sd1
                                                                       : item_reg.request_param;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = res_cpl;
                        state_next      = S_FLUSH;
                    end else if (last_slot) begin
                        pend_valid_next = 1'b1;
                        pend_next       = res_cpl;
                        state_next      = S_FLUSH;
                    end else begin
                        slot_next  = slot_reg + SW'(1);
                        state_next = S_REQ_RD;
                    end
                end else begin
                    if (entry == item_reg.requester_id) begin
                        ram_we               = 1'b1;
                        ram_wdata            = 8'h00;
                        valid_next[cur_addr] = 1'b1;
                        hit_next             = 1'b1;
                    end
                    if (last_slot) begin
                        pend_valid_next = 1'b1;
                        pend_next       = res_cpl;
                        state_next      = S_FLUSH;
                    end else begin
                        slot_next  = slot_reg + SW'(1);
                        state_next = S_REQ_RD;
                    end
                end
            end

            // Hand the held beat over with last set
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = pend_reg;
                    m_data_next.last = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            h0_reg         <= 3'b111;
            h1_reg         <= 3'b111;
            ref_reg        <= 16'h0000;
            sens_reg       <= 16'sd1;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            h0_reg         <= h0_next;
            h1_reg         <= h1_next;
            ref_reg        <= ref_next;
            sens_reg       <= sens_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        item_reg   <= item_next;
        press_reg  <= press_next;
        kind_reg   <= kind_next;
        slot_reg   <= slot_next;
        evv_reg    <= evv_next;
        hit_reg    <= hit_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        if (ram_re) begin
            rd_valid_reg <= valid_reg[cur_addr];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // A new item never starts with a beat still held back
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result beat left over at idle");

    // The divider is only restarted once it has finished
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // Table writes come only from request handling
    a_ram_we: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_REQ_CHK && item_reg.req_type != REQ_TICK))
        else $error("subscriber table written outside a request");

    // A nonzero dial step moves the encoder reference to the sampled count
    a_ref_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV_WAIT && !div_rsp.busy && div_rsp.quotient != '0)
        |=> (ref_reg == $past(item_reg.encoder_count)))
        else $error("encoder reference not updated on dial step");

    // Sensitivity is never zero, so the divisor never is
    a_sens_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sens_reg != 16'sd0)
        else $error("dial sensitivity became zero");
`endif

endmodule

`default_nettype wire

/* test/tb_button_encoder_event_dispatcher_unit.sv */
// Self-checking testbench for the button/encoder event dispatcher: sends ticks and
// subscriber requests, predicts every result beat in a local model, checks the output.
// Depends on bed_pkg and button_encoder_event_dispatcher_unit.
module tb_button_encoder_event_dispatcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bed_pkg::*;

    localparam int SLOTS = SLOTS_PER_KIND_DEF;
    localparam int KINDS = NUM_KINDS_DEF;
    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam logic [PADDR_W-1:0] TPD_ADDR = PADDR_W'(4 * REG_TPD);
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS = 40;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;

    button_encoder_event_dispatcher_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Local copy of the dispatcher state
    logic [7:0]  subs [KINDS*SLOTS];
    logic [1:0]  btn_hist [3];      // [0] previous sample, [1] the one before
    logic [15:0] enc_ref;
    int          dial_sens;
    logic [3:0]  tpd;

    in_item_t    queued_requests[$];
    out_item_t   owed_results[$];
    out_item_t   item_results[$];

    int errors = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int events_seen = 0;
    int completions_seen = 0;

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // One event beat per nonzero subscriber of the kind, slot order
    function automatic void post_event(input logic [1:0] kind, input logic signed [15:0] val);
        out_item_t r;
        for (int s = 0; s < SLOTS; s++) begin
            if (subs[kind*SLOTS + s] != 8'd0) begin
                r = '0;
                r.result_kind    = RES_EVENT;
                r.destination_id = subs[kind*SLOTS + s];
                r.event_kind     = kind;
                r.event_value    = val;
                r.status_code    = STAT_OK;
                item_results.push_back(r);
            end
        end
    endfunction

    // Update the state for one accepted beat and queue the results it owes
    task automatic dispatch_predict(input in_item_t it);
        logic [2:0]         lvls;
        logic               lvl;
        logic [15:0]        delta;
        int                 diff;
        int                 divisor;
        int                 quot;
        int                 base;
        logic [1:0]         st;
        logic               hit;
        logic signed [15:0] prm;
        out_item_t          r;
        item_results.delete();
        if (it.req_type == REQ_TICK) begin
            lvls = {it.btn_other_level, it.btn_capture_level, it.btn_mode_level};
            // debounce: two agreeing samples that differ from the older history
            for (int b = 0; b < 3; b++) begin
                lvl = lvls[b];
                if (lvl != btn_hist[b][1] && lvl == btn_hist[b][0]) begin
                    btn_hist[b][1] = btn_hist[b][0];
                    if (!lvl) post_event(2'(b), 16'sd0);
                end
                if (lvl != btn_hist[b][0]) begin
                    btn_hist[b][1] = btn_hist[b][0];
                    btn_hist[b][0] = lvl;
                end
            end
            // dial step: truncating divide, +32768 saturates
            delta = it.encoder_count - enc_ref;
            diff = $signed(delta);
            divisor = ((tpd == 4'd0) ? 1 : int'(tpd)) * dial_sens;
            quot = diff / divisor;
            if (quot > 32767) quot = 32767;
            if (quot != 0) begin
                post_event(KIND_DIAL, 16'(quot));
                enc_ref = it.encoder_count;
            end
        end else begin
            st = STAT_ERR;
            base = it.source_kind * SLOTS;
            if (it.req_type == REQ_BAD) begin
                st = STAT_ERR;
            end else if (it.source_kind >= KINDS) begin
                st = STAT_BAD_PARAM;
            end else if (it.req_type == REQ_REG) begin
                hit = 1'b0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!hit && subs[base + s] == 8'd0) begin
                        hit = 1'b1;
                        subs[base + s] = it.requester_id;
                        if (it.source_kind == KIND_DIAL) begin
                            prm = it.request_param;
                            dial_sens = (prm != 0) ? int'(prm) : 1;
                        end
                        st = STAT_OK;
                    end
                end
            end else begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (subs[base + s] == it.requester_id) begin
                        subs[base + s] = 8'd0;
                        st = STAT_OK;
                    end
                end
            end
            r = '0;
            r.result_kind    = RES_COMPLETION;
            r.destination_id = it.requester_id;
            r.status_code    = st;
            item_results.push_back(r);
        end
        if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
        foreach (item_results[i]) owed_results.push_back(item_results[i]);
    endtask

    // Sender: bursts of beats with random gaps, fed from the request queue
    int burst_left = 0;
    int gap_left = 0;
    int gap_max = 8;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                dispatch_predict(s_data);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_requests.size() > 0) begin
                    s_data  <= queued_requests.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready patterns from a 16-bit word, plus long holds on request
    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_pos = 0;
    int          hold_left = 0;
    logic        hold_request = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request || hold_left > 0) begin
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (pat_pos == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pat = 16'hFFFF;
                    1: ready_pat = 16'($urandom);
                    2: ready_pat = 16'($urandom | $urandom);
                    default: ready_pat = 16'($urandom & $urandom);
                endcase
            end
            m_ready <= ready_pat[pat_pos];
            pat_pos = (pat_pos + 1) % 16;
        end
    end

    // Output checker: every beat against the oldest owed result
    always @(posedge aclk) begin : check_proc
        out_item_t want;
        string     bad;
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (m_data.result_kind == RES_EVENT) events_seen++;
            else completions_seen++;
            if (owed_results.size() == 0) begin
                flag_mismatch($sformatf("beat %0d not owed: %p", beats_checked, m_data));
            end else begin
                want = owed_results.pop_front();
                bad = "";
                if (m_data.result_kind !== want.result_kind) bad = {bad, " result_kind"};
                if (m_data.destination_id !== want.destination_id) bad = {bad, " destination_id"};
                if (m_data.event_kind !== want.event_kind) bad = {bad, " event_kind"};
                if (m_data.event_value !== want.event_value) bad = {bad, " event_value"};
                if (m_data.status_code !== want.status_code) bad = {bad, " status_code"};
                if (m_data.last !== want.last) bad = {bad, " last"};
                if (bad != "")
                    flag_mismatch($sformatf("beat %0d wrong%s: got %p want %p",
                                            beats_checked, bad, m_data, want));
            end
        end
    end

    // Stimulus generation
    logic [2:0]  gen_levels = 3'b111;
    logic [15:0] gen_count = 16'h0000;
    int          detent_mid;

    task automatic queue_item(input logic [1:0] rq, input logic [2:0] lv,
                              input logic [15:0] cnt, input logic [2:0] kind,
                              input logic [7:0] id, input logic [15:0] prm);
        in_item_t it;
        it.req_type          = rq;
        it.btn_mode_level    = lv[0];
        it.btn_capture_level = lv[1];
        it.btn_other_level   = lv[2];
        it.encoder_count     = cnt;
        it.source_kind       = kind;
        it.requester_id      = id;
        it.request_param     = prm;
        queued_requests.push_back(it);
    endtask

    // Mostly ticks with slowly moving buttons and encoder, mixed with table edits and some bad requests
    task automatic queue_random(input int n);
        in_item_t    it;
        logic [63:0] noise;
        int          pick;
        logic [7:0]  pool [6] = '{8'h00, 8'h01, 8'h33, 8'h44, 8'h80, 8'hFF};
        for (int i = 0; i < n; i++) begin
            noise = {$urandom, $urandom};
            it = noise[$bits(in_item_t)-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                it.req_type = REQ_TICK;
                for (int b = 0; b < 3; b++)
                    if ($urandom_range(0, 3) == 0) gen_levels[b] = ~gen_levels[b];
                it.btn_mode_level    = gen_levels[0];
                it.btn_capture_level = gen_levels[1];
                it.btn_other_level   = gen_levels[2];
                if ($urandom_range(0, 19) == 0) gen_count = 16'($urandom);
                else gen_count = gen_count + 16'($urandom_range(0, 120)) - 16'd60;
                it.encoder_count = gen_count;
            end else if (pick < 96) begin
                it.req_type = (pick < 82) ? REQ_REG : REQ_UNREG;
                if ($urandom_range(0, 9) != 0) it.source_kind = 3'($urandom_range(0, 3));
                if ($urandom_range(0, 7) != 0) it.requester_id = pool[$urandom_range(0, 5)];
                if ($urandom_range(0, 15) != 0)
                    it.request_param = 16'(int'($urandom_range(0, 8)) - 4);
            end else if (pick < 98) begin
                it.req_type = REQ_BAD;
            end else begin
                it.req_type = 2'($urandom_range(1, 2));
                it.source_kind = 3'($urandom_range(4, 7));
            end
            queued_requests.push_back(it);
        end
    endtask

    // Everything sent, every owed beat seen, then let a quiet item finish
    task automatic wait_idle();
        @(negedge aclk);
        while (queued_requests.size() != 0 || s_valid || owed_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_detent(input logic [3:0] v);
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= TPD_ADDR;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tpd = v;
    endtask

    task automatic hold_output_later();
        while (queued_requests.size() > 60) @(negedge aclk);
        hold_request = 1'b1;
    endtask

    initial begin : stimulus
        logic [15:0] pivot;
        int          guard;
        foreach (subs[i]) subs[i] = 8'd0;
        foreach (btn_hist[b]) btn_hist[b] = 2'b11;
        enc_ref = 16'h0000;
        dial_sens = 1;
        tpd = TPD_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // malformed request, kinds out of range, fill and overfill the table, id zero
        queue_item(REQ_BAD,   3'b111, 16'h0000, 3'd0, 8'h11, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, 3'd7, 8'h22, 16'h0000);
        queue_item(REQ_UNREG, 3'b111, 16'h0000, 3'd4, 8'h22, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_MODE, 8'hFF, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_MODE, 8'h01, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_MODE, 8'h02, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_CAPTURE, 8'h80, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_OTHER, 8'h00, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_OTHER, 8'h7E, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_DIAL, 8'h5A, 16'h8000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_DIAL, 8'hA5, 16'h0000);
        queue_item(REQ_UNREG, 3'b111, 16'h0000, KIND_CAPTURE, 8'h33, 16'h0000);
        queue_item(REQ_UNREG, 3'b111, 16'h0000, KIND_OTHER, 8'h00, 16'h0000);
        // quiet tick, presses, chatter on mode, encoder extremes both ways
        queue_item(REQ_TICK,  3'b111, 16'h0001, 3'd0, 8'h00, 16'h0000);
        queue_item(REQ_TICK,  3'b010, 16'h7FFF, 3'd0, 8'h00, 16'h0000);
        queue_item(REQ_TICK,  3'b000, 16'hFFFF, 3'd0, 8'h00, 16'h0000);
        queue_item(REQ_TICK,  3'b001, 16'hFFFF, 3'd0, 8'h00, 16'h0000);
        queue_item(REQ_TICK,  3'b000, 16'h0000, 3'd0, 8'h00, 16'h0000);
        queue_item(REQ_TICK,  3'b000, 16'h0000, 3'd0, 8'h00, 16'h0000);
        queue_item(REQ_TICK,  3'b111, 16'h8000, 3'd0, 8'h00, 16'h0000);
        wait_idle();

        // one count per step, sensitivity -1: a half-turn back saturates the step
        write_detent(4'd1);
        pivot = enc_ref ^ 16'h8000;
        queue_item(REQ_UNREG, 3'b111, 16'h0000, KIND_DIAL, 8'hA5, 16'h0000);
        queue_item(REQ_UNREG, 3'b111, 16'h0000, KIND_DIAL, 8'h5A, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_DIAL, 8'h33, 16'hFFFF);
        queue_item(REQ_TICK,  3'b111, pivot,    3'd0, 8'h00, 16'h0000);
        queue_item(REQ_REG,   3'b111, 16'h0000, KIND_DIAL, 8'h44, 16'h7FFF);
        wait_idle();

        // random traffic over several detent settings
        write_detent(4'd0);
        queue_random(90);
        hold_output_later();
        wait_idle();

        write_detent(4'd15);
        queue_random(90);
        wait_idle();

        detent_mid = $urandom_range(3, 13);
        write_detent(4'(detent_mid));
        queue_random(90);
        hold_output_later();
        wait_idle();

        // back-to-back beats on the input side
        write_detent(4'd2);
        gap_max = 0;
        queue_random(100);

        guard = 0;
        @(negedge aclk);
        while ((queued_requests.size() != 0 || s_valid || owed_results.size() != 0)
               && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (owed_results.size() != 0)
            flag_mismatch($sformatf("%0d owed beats never arrived", owed_results.size()));

        $display("Sent %0d beats (ticks and subscriber requests) at detent 2, 1, 0, 15, %0d, 2,",
                 items_sent, detent_mid);
        $display("checked %0d result beats (%0d events, %0d completions), %0d mismatches.",
                 beats_checked, events_seen, completions_seen, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #12000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
